// ===== rtl/otq_pkg.sv =====
package otq_pkg;

  localparam int CAPACITY   = 32;
  localparam int TIME_BITS  = 48;
  localparam int ID_BITS    = 32;
  localparam int DELAY_BITS = 31;
  localparam int REQ_BITS   = 2;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int SUM_BITS   = ((TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS) + 1;

  localparam logic [REQ_BITS-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_TICK   = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_DONE      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] deadline;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 found;
    logic [TIME_BITS-1:0] key_dl;
    logic [ID_BITS-1:0]   key_id;
  } ctrl_t;

  typedef struct packed {
    logic stay;
    logic ge;
    logic match;
  } flags_t;

endpackage

// ===== rtl/otq_cell.sv =====
module otq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  otq_pkg::ctrl_t ctrl_i,
  input  otq_pkg::entry_t left_i,
  input  logic           left_stay_i,
  input  otq_pkg::entry_t right_i,
  output otq_pkg::entry_t entry_o,
  output otq_pkg::flags_t flags_o
);
  import otq_pkg::*;

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic                 lt, eq;

  assign eq = (dl_q == ctrl_i.key_dl) && (id_q == ctrl_i.key_id);
  assign lt = (dl_q < ctrl_i.key_dl) || ((dl_q == ctrl_i.key_dl) && (id_q < ctrl_i.key_id));

  assign flags_o.stay  = valid_q && (lt || eq);
  assign flags_o.ge    = valid_q && !lt;
  assign flags_o.match = valid_q && eq;

  assign entry_o.valid    = valid_q;
  assign entry_o.deadline = dl_q;
  assign entry_o.id       = id_q;

  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    id_d    = id_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (!flags_o.stay) begin
          if (left_stay_i) begin
            valid_d = 1'b1;
            dl_d    = ctrl_i.key_dl;
            id_d    = ctrl_i.key_id;
          end else begin
            valid_d = left_i.valid;
            dl_d    = left_i.deadline;
            id_d    = left_i.id;
          end
        end
      end
      CMD_DELETE: begin
        if (ctrl_i.found && flags_o.ge) begin
          valid_d = right_i.valid;
          dl_d    = right_i.deadline;
          id_d    = right_i.id;
        end
      end
      CMD_POP: begin
        valid_d = right_i.valid;
        dl_d    = right_i.deadline;
        id_d    = right_i.id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d;
    id_q <= id_d;
  end

endmodule

// ===== rtl/ordered_timer_queue_top.sv =====
// Channel | Valid      | Stall       | Payload
// request | in_valid_i | in_stall_o  | req_type_i, now_ms_i, delay_ms_i,
//         |            |             | target_deadline_i, target_id_i
// result  | out_valid_o| out_stall_i | status_o, timer_id_o, deadline_o,
//         |            |             | next_deadline_o, queue_empty_o, last_o
//
// Add, delete and unused requests first latch the key (the saturating add
// sits here), then the chain of 32 cells inserts or shifts.
// A tick latches the key, scans the chain for the surviving head, then
// emits one beat per expiry and a closing beat.
// Reset empties the chain at once through the per-cell valid flags.
// A stalled result beat holds the chain; the next request is taken as soon
// as the last beat of the current one sits in the output register.
module ordered_timer_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [otq_pkg::REQ_BITS-1:0]   req_type_i,
  input  logic [otq_pkg::TIME_BITS-1:0]  now_ms_i,
  input  logic [otq_pkg::DELAY_BITS-1:0] delay_ms_i,
  input  logic [otq_pkg::TIME_BITS-1:0]  target_deadline_i,
  input  logic [otq_pkg::ID_BITS-1:0]    target_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [otq_pkg::ID_BITS-1:0]    timer_id_o,
  output logic [otq_pkg::TIME_BITS-1:0]  deadline_o,
  output logic [otq_pkg::TIME_BITS-1:0]  next_deadline_o,
  output logic                          queue_empty_o,
  output logic                          last_o
);
  import otq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_EXPIRE = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [REQ_BITS-1:0]  req_q;
  logic [TIME_BITS-1:0] key_dl_q;
  logic [ID_BITS-1:0]   key_id_q;
  logic [ID_BITS-1:0]   next_id_q, next_id_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [TIME_BITS-1:0] nd_q, nd_d;
  logic                 empty_q, empty_d;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ID_BITS-1:0]   out_id_q;
  logic [TIME_BITS-1:0] out_dl_q;
  logic [TIME_BITS-1:0] out_nd_q;
  logic                 out_empty_q;
  logic                 out_last_q;

  logic                 accept, out_free, emit;
  status_e              e_status;
  logic [ID_BITS-1:0]   e_id;
  logic [TIME_BITS-1:0] e_dl;
  logic [TIME_BITS-1:0] e_nd;
  logic                 e_empty;
  logic                 e_last;

  logic [SUM_BITS-1:0]  sum;
  logic [TIME_BITS-1:0] sat_dl;

  ctrl_t                ctrl;
  entry_t               entry [CAPACITY];
  flags_t               flags [CAPACITY];
  logic                 found, full;
  logic [TIME_BITS-1:0] head_dl, second_dl, tick_nd;
  logic                 tick_any;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sum    = SUM_BITS'(now_ms_i) + SUM_BITS'(delay_ms_i);
  assign sat_dl = (sum[SUM_BITS-1:TIME_BITS] != '0) ? '1 : sum[TIME_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      case (req_type_i)
        REQ_ADD: begin
          key_dl_q <= sat_dl;
          key_id_q <= next_id_q;
        end
        REQ_TICK: begin
          key_dl_q <= now_ms_i;
          key_id_q <= '1;
        end
        default: begin
          key_dl_q <= target_deadline_i;
          key_id_q <= target_id_i;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left, right;
    logic   left_stay;
    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_stay = 1'b1;
    end else begin : g_body
      assign left      = entry[i-1];
      assign left_stay = flags[i-1].stay;
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = entry[i+1];
    end
    otq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .left_stay_i (left_stay),
      .right_i     (right),
      .entry_o     (entry[i]),
      .flags_o     (flags[i])
    );
  end

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | flags[i].match;
    end
  end

  always_comb begin
    tick_nd  = '0;
    tick_any = 1'b0;
    if (entry[0].valid && !flags[0].stay) begin
      tick_nd  = entry[0].deadline;
      tick_any = 1'b1;
    end
    for (int i = 1; i < CAPACITY; i++) begin
      if (entry[i].valid && !flags[i].stay && flags[i-1].stay) begin
        tick_nd  = tick_nd | entry[i].deadline;
        tick_any = 1'b1;
      end
    end
  end

  assign full      = (cnt_q == CNT_BITS'(CAPACITY));
  assign head_dl   = entry[0].valid ? entry[0].deadline : '0;
  assign second_dl = entry[1].valid ? entry[1].deadline : '0;

  always_comb begin
    state_d   = state_q;
    next_id_d = next_id_q;
    cnt_d     = cnt_q;
    nd_d      = nd_q;
    empty_d   = empty_q;
    emit      = 1'b0;
    e_status  = ST_DONE;
    e_id      = '0;
    e_dl      = '0;
    e_nd      = head_dl;
    e_empty   = (cnt_q == '0);
    e_last    = 1'b1;
    ctrl.cmd    = CMD_HOLD;
    ctrl.found  = found;
    ctrl.key_dl = key_dl_q;
    ctrl.key_id = key_id_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q == REQ_TICK) begin
          nd_d    = tick_nd;
          empty_d = !tick_any;
          state_d = S_EXPIRE;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (req_q)
            REQ_ADD: begin
              if (full) begin
                e_status = ST_FULL;
              end else begin
                ctrl.cmd  = CMD_INSERT;
                e_status  = ST_ADDED;
                e_id      = key_id_q;
                e_dl      = key_dl_q;
                e_nd      = flags[0].stay ? entry[0].deadline : key_dl_q;
                e_empty   = 1'b0;
                cnt_d     = cnt_q + 1'b1;
                next_id_d = next_id_q + 1'b1;
              end
            end
            REQ_DELETE: begin
              if (found) begin
                ctrl.cmd = CMD_DELETE;
                e_status = ST_DELETED;
                e_nd     = flags[0].ge ? second_dl : head_dl;
                e_empty  = (cnt_q == CNT_BITS'(1));
                cnt_d    = cnt_q - 1'b1;
              end else begin
                e_status = ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EXPIRE: begin
        e_nd    = nd_q;
        e_empty = empty_q;
        if (out_free) begin
          emit = 1'b1;
          if (flags[0].stay) begin
            ctrl.cmd = CMD_POP;
            e_status = ST_EXPIRED;
            e_id     = entry[0].id;
            e_dl     = entry[0].deadline;
            e_last   = 1'b0;
            cnt_d    = cnt_q - 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_id_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      cnt_q     <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q    <= nd_d;
    empty_q <= empty_d;
    if (emit) begin
      out_status_q <= e_status;
      out_id_q     <= e_id;
      out_dl_q     <= e_dl;
      out_nd_q     <= e_nd;
      out_empty_q  <= e_empty;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign timer_id_o      = out_id_q;
  assign deadline_o      = out_dl_q;
  assign next_deadline_o = out_nd_q;
  assign queue_empty_o   = out_empty_q;
  assign last_o          = out_last_q;

endmodule

// ===== rtl/ordered_timer_queue_chk.sv =====
module ordered_timer_queue_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    status_o,
  input logic [otq_pkg::ID_BITS-1:0]    timer_id_o,
  input logic [otq_pkg::TIME_BITS-1:0]  deadline_o,
  input logic [otq_pkg::TIME_BITS-1:0]  next_deadline_o,
  input logic                          queue_empty_o,
  input logic                          last_o
);
  import otq_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while a request was still in flight");

  a_empty_no_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && queue_empty_o) |-> (next_deadline_o == '0))
    else $error("empty queue reports a pending deadline");

  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EXPIRED)) |-> !last_o)
    else $error("expiry beat flagged as last");

  a_added_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_ADDED)) |->
      (!queue_empty_o && (next_deadline_o <= deadline_o)))
    else $error("added timer earlier than reported head");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(timer_id_o) && $stable(last_o)))
    else $error("stalled result beat changed");

endmodule

bind ordered_timer_queue_top ordered_timer_queue_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .timer_id_o      (timer_id_o),
  .deadline_o      (deadline_o),
  .next_deadline_o (next_deadline_o),
  .queue_empty_o   (queue_empty_o),
  .last_o          (last_o)
);
